// File: sv/gcidw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcidw_pkg - shared types and constants
// Widths, configuration layout, sequencer states and helpers for the grid
// corner interpolator.
// ----------------------------------------------------------------------------
package gcidw_pkg;

  localparam int MAX_AXES   = 4;
  localparam int CORNERS    = 1 << MAX_AXES;
  localparam int CI_W       = MAX_AXES;
  localparam int AX_W       = $clog2(MAX_AXES);
  localparam int GRID_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int VALUE_W    = 16;
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 7;
  localparam int RANK_W     = 3;
  localparam int COUNT_W    = 13;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  // datapath widths
  localparam int F_W    = 17;   // coordinate minus grid point, Q8
  localparam int SQ_W   = 32;   // squared difference
  localparam int RAW_W  = 34;   // sum of squared differences
  localparam int DIST_W = 16;   // normalized distance
  localparam int WT_W   = 24;   // normalized weight
  localparam int WP_W   = 40;   // weight times distance
  localparam int MA_W   = 25;
  localparam int MB_W   = 18;
  localparam int MP_W   = MA_W + MB_W;
  localparam int ACC_W  = 45;
  localparam int NUM_W  = 44;
  localparam int NORM_W = 29;
  localparam int BL_W   = 6;

  localparam logic [RAW_W-1:0] SINGLE_DIST = RAW_W'(655);  // 0.01 in Q16

  typedef enum logic [2:0] {
    REG_AXIS_COUNT,
    REG_AXIS0_SIZE,
    REG_AXIS1_SIZE,
    REG_AXIS2_SIZE,
    REG_AXIS3_SIZE,
    REG_ELEMENT_COUNT
  } reg_idx_t;

  typedef struct packed {
    logic [RANK_W-1:0]                axis_count;
    logic [MAX_AXES-1:0][SIZE_W-1:0]  axis_size;
    logic [COUNT_W-1:0]               element_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIST,
    ST_DWAIT,
    ST_DNORM,
    ST_WMUL,
    ST_WWAIT,
    ST_WNORM,
    ST_RD,
    ST_MV,
    ST_AWAIT,
    ST_DIVS,
    ST_DIVW,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    WB_DIST,
    WB_WGT,
    WB_ACC
  } wb_kind_t;

  // writeback tag for the registered multiplier product
  typedef struct packed {
    logic             vld;
    wb_kind_t         kind;
    logic [CI_W-1:0]  idx;
    logic [AX_W-1:0]  ax;
    logic             last;
  } wb_t;

  function automatic logic [BL_W-1:0] bit_len(input logic [WP_W-1:0] v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int b = 0; b < WP_W; b++) begin
      if (v[b]) n = BL_W'(b + 1);
    end
    return n;
  endfunction

endpackage

// File: sv/gcidw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcidw_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gcidw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

endmodule

// File: sv/gcidw_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcidw_mul - shared signed multiplier
// 25x18 signed product with a registered output.
// ----------------------------------------------------------------------------
module gcidw_mul import gcidw_pkg::*; (
  input  logic                   clk,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [MP_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// File: sv/gcidw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcidw_div - radix-2 restoring divider
// Unsigned quotient, one bit per cycle, done pulses after NUM_W steps.
// ----------------------------------------------------------------------------
module gcidw_div import gcidw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [NORM_W-1:0] den,
  output logic              done_r,
  output logic [NUM_W-1:0]  quo_r
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NORM_W-1:0] rem_r;
  logic [NORM_W:0]   shifted;
  logic [NORM_W:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    ge      = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[NORM_W-1:0] : shifted[NORM_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

endmodule

// File: sv/gcidw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcidw_core - sequencer and datapath
// Grid store, corner distances, weight products, weighted sum and division,
// all through one shared multiplier and one divider.
// ----------------------------------------------------------------------------
module gcidw_core import gcidw_pkg::*; (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cfg_t                               cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic [ADDR_W-1:0]                  in_write_address,
  input  logic [VALUE_W-1:0]                 in_write_value,
  input  logic [MAX_AXES-1:0][COORD_W-1:0]   in_coord,
  input  logic                               out_ready,
  output logic                               out_valid_r,
  output logic [VALUE_W-1:0]                 out_interpolated_r,
  output logic                               out_status_r
);

  state_t state_r, state_nxt;

  logic [CI_W-1:0]   ci_r, k_r, last_ci_r;
  logic [AX_W-1:0]   aj_r;
  logic [RANK_W-1:0] rank_r;
  wb_t               wb_r;

  logic [COORD_W-1:0] coord_r [MAX_AXES];
  logic [SIZE_W-1:0]  lo_r    [MAX_AXES];
  logic [SIZE_W-1:0]  size_r  [MAX_AXES];
  logic [MAX_AXES-1:0] single_r;
  logic [ADDR_W-1:0]  strd_r  [MAX_AXES];
  logic [ADDR_W-1:0]  base_r, stride_r;

  logic [RAW_W-1:0]  dacc_r, dmax_r;
  logic [RAW_W-1:0]  raw_r [CORNERS];
  logic [DIST_W-1:0] dn_r  [CORNERS];
  logic [WP_W-1:0]   w_r   [CORNERS];
  logic [WP_W-1:0]   wmax_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [NORM_W-1:0] norm_r;
  logic [VALUE_W-1:0] res_r;
  logic               stat_r;

  // query setup values
  logic [SIZE_W-1:0]   q_size [MAX_AXES];
  logic [SIZE_W-1:0]   q_lo   [MAX_AXES];
  logic [MAX_AXES-1:0] q_single;
  logic [RANK_W-1:0]   q_rank;

  logic                  do_accept, emit_go;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod_r;
  logic [SIZE_W-1:0]     pt_idx;
  logic [F_W-1:0]        fdiff;
  logic [ADDR_W-1:0]     corner_addr;
  logic [VALUE_W-1:0]    ram_rdata;
  logic [RAW_W-1:0]      dterm, dsum;
  logic [BL_W-1:0]       dbl, wbl;
  logic [BL_W-1:0]       dsh, wsh;
  logic [DIST_W-1:0]     dn_nxt [CORNERS];
  logic [RAW_W-1:0]      dt     [CORNERS];
  logic [NUM_W-1:0]      div_num, div_quo, mean_mag;
  logic                  div_start, div_done;
  logic [AX_W-1:0]       rank_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign do_accept = in_valid && in_ready;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign rank_last = AX_W'(rank_r - RANK_W'(1));

  // lower index and singleton flags per axis
  always_comb begin
    for (int j = 0; j < MAX_AXES; j++) begin
      q_size[j]   = (cfg.axis_size[j] == '0) ? SIZE_W'(1) : cfg.axis_size[j];
      q_single[j] = (q_size[j] == SIZE_W'(1));
      q_lo[j]     = in_coord[j][COORD_W-1] ? '0 : in_coord[j][COORD_W-2:8];
      if (q_lo[j] >= q_size[j] - SIZE_W'(1)) q_lo[j] = q_size[j] - SIZE_W'(2);
      if (q_single[j]) q_lo[j] = '0;
    end
    if (cfg.axis_count == '0)                      q_rank = RANK_W'(1);
    else if (cfg.axis_count > RANK_W'(MAX_AXES))   q_rank = RANK_W'(MAX_AXES);
    else                                           q_rank = cfg.axis_count;
  end

  // operand selection for the shared multiplier
  always_comb begin
    pt_idx = lo_r[aj_r] + SIZE_W'(ci_r[aj_r]);
    fdiff  = {coord_r[aj_r][COORD_W-1], coord_r[aj_r]} - {2'b00, pt_idx, 8'h00};
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      ST_DIST: begin
        mul_a = {{(MA_W-F_W){fdiff[F_W-1]}}, fdiff};
        mul_b = {{(MB_W-F_W){fdiff[F_W-1]}}, fdiff};
      end
      ST_WMUL: begin
        mul_a = {1'b0, w_r[ci_r][WT_W-1:0]};
        mul_b = (ci_r == k_r) ? MB_W'(1) : {2'b00, dn_r[k_r]};
      end
      ST_MV: begin
        mul_a = {1'b0, w_r[ci_r][WT_W-1:0]};
        mul_b = {{(MB_W-VALUE_W){ram_rdata[VALUE_W-1]}}, ram_rdata};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // corner address: base plus strides of upper-index axes
  always_comb begin
    corner_addr = base_r;
    for (int j = 0; j < MAX_AXES; j++) begin
      if (ci_r[j] && !single_r[j]) corner_addr = corner_addr + strd_r[j];
    end
  end

  // distance writeback, distance and weight normalization, division operands
  always_comb begin
    dterm = single_r[wb_r.ax] ? SINGLE_DIST : {2'b00, prod_r[SQ_W-1:0]};
    dsum  = dacc_r + dterm;
    dbl   = bit_len(WP_W'(dmax_r));
    dsh   = (dbl > BL_W'(DIST_W)) ? dbl - BL_W'(DIST_W) : '0;
    wbl   = bit_len(wmax_r);
    wsh   = (wbl > BL_W'(WT_W)) ? wbl - BL_W'(WT_W) : '0;
    for (int i = 0; i < CORNERS; i++) begin
      dt[i]     = raw_r[i] >> dsh;
      dn_nxt[i] = (dt[i] == '0 && raw_r[i] != '0) ? DIST_W'(1) : dt[i][DIST_W-1:0];
    end
    div_num  = acc_r[ACC_W-1] ? NUM_W'(-acc_r) : NUM_W'(acc_r);
    mean_mag = acc_r[ACC_W-1] ? -div_quo : div_quo;
  end

  assign div_start = (state_r == ST_DIVS);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (do_accept && in_operation)
                  state_nxt = (cfg.element_count == '0) ? ST_EMIT : ST_PREP;
      ST_PREP:  if (aj_r == AX_W'(MAX_AXES - 1)) state_nxt = ST_DIST;
      ST_DIST:  if (aj_r == rank_last && ci_r == last_ci_r) state_nxt = ST_DWAIT;
      ST_DWAIT: state_nxt = ST_DNORM;
      ST_DNORM: state_nxt = ST_WMUL;
      ST_WMUL:  if (ci_r == last_ci_r) state_nxt = ST_WWAIT;
      ST_WWAIT: state_nxt = ST_WNORM;
      ST_WNORM: state_nxt = (k_r == last_ci_r) ? ST_RD : ST_WMUL;
      ST_RD:    state_nxt = ST_MV;
      ST_MV:    state_nxt = (ci_r == last_ci_r) ? ST_AWAIT : ST_RD;
      ST_AWAIT: state_nxt = ST_DIVS;
      ST_DIVS:  state_nxt = ST_DIVW;
      ST_DIVW:  if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ci_r        <= '0;
      aj_r        <= '0;
      k_r         <= '0;
      wb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          wb_r.vld <= 1'b0;
          ci_r     <= '0;
          aj_r     <= '0;
          k_r      <= '0;
        end
        ST_PREP: begin
          wb_r.vld <= 1'b0;
          aj_r     <= aj_r + AX_W'(1);
        end
        ST_DIST: begin
          wb_r <= '{vld: 1'b1, kind: WB_DIST, idx: ci_r, ax: aj_r,
                    last: (aj_r == rank_last)};
          if (aj_r == rank_last) begin
            aj_r <= '0;
            ci_r <= ci_r + CI_W'(1);
          end else begin
            aj_r <= aj_r + AX_W'(1);
          end
        end
        ST_DWAIT, ST_DNORM: begin
          wb_r.vld <= 1'b0;
          ci_r     <= '0;
        end
        ST_WMUL: begin
          wb_r <= '{vld: 1'b1, kind: WB_WGT, idx: ci_r, ax: '0, last: 1'b0};
          ci_r <= ci_r + CI_W'(1);
        end
        ST_WNORM: begin
          wb_r.vld <= 1'b0;
          ci_r     <= '0;
          k_r      <= k_r + CI_W'(1);
        end
        ST_MV: begin
          wb_r <= '{vld: 1'b1, kind: WB_ACC, idx: ci_r, ax: '0, last: 1'b0};
          ci_r <= ci_r + CI_W'(1);
        end
        default: wb_r.vld <= 1'b0;
      endcase
      if (emit_go)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (do_accept && in_operation) begin
      for (int j = 0; j < MAX_AXES; j++) begin
        coord_r[j] <= in_coord[j];
        lo_r[j]    <= q_lo[j];
        size_r[j]  <= q_size[j];
      end
      single_r  <= q_single;
      rank_r    <= q_rank;
      last_ci_r <= CI_W'((32'd1 << q_rank) - 32'd1);
      base_r    <= '0;
      stride_r  <= ADDR_W'(1);
      dacc_r    <= '0;
      dmax_r    <= '0;
      acc_r     <= '0;
      norm_r    <= '0;
      res_r     <= '0;
      stat_r    <= 1'b1;
    end

    if (state_r == ST_PREP) begin
      strd_r[aj_r] <= stride_r;
      if (RANK_W'(aj_r) < rank_r) base_r <= base_r + ADDR_W'(lo_r[aj_r] * stride_r);
      stride_r <= ADDR_W'(stride_r * size_r[aj_r]);
    end

    if (wb_r.vld) begin
      unique case (wb_r.kind)
        WB_DIST: begin
          if (wb_r.last) begin
            raw_r[wb_r.idx] <= dsum;
            if (dsum > dmax_r) dmax_r <= dsum;
            dacc_r <= '0;
          end else begin
            dacc_r <= dsum;
          end
        end
        WB_WGT: begin
          w_r[wb_r.idx] <= prod_r[WP_W-1:0];
          if (prod_r[WP_W-1:0] > wmax_r) wmax_r <= prod_r[WP_W-1:0];
        end
        WB_ACC: acc_r <= acc_r + {{(ACC_W-MP_W){prod_r[MP_W-1]}}, prod_r};
        default: ;
      endcase
    end

    if (state_r == ST_DNORM) begin
      for (int i = 0; i < CORNERS; i++) begin
        dn_r[i] <= dn_nxt[i];
        w_r[i]  <= WP_W'(1);
      end
      wmax_r <= '0;
    end

    if (state_r == ST_WNORM) begin
      for (int i = 0; i < CORNERS; i++) w_r[i] <= w_r[i] >> wsh;
      wmax_r <= '0;
    end

    if (state_r == ST_MV) norm_r <= norm_r + NORM_W'(w_r[ci_r][WT_W-1:0]);

    if (state_r == ST_DIVW && div_done) begin
      res_r  <= (norm_r == '0) ? '0 : mean_mag[VALUE_W-1:0];
      stat_r <= 1'b0;
    end

    if (emit_go) begin
      out_interpolated_r <= res_r;
      out_status_r       <= stat_r;
    end
  end

  gcidw_ram #(.WIDTH(VALUE_W), .DEPTH(GRID_DEPTH)) u_ram (
    .clk     (clk),
    .we      (do_accept && !in_operation),
    .waddr   (in_write_address),
    .wdata   (in_write_value),
    .raddr   (corner_addr),
    .rdata_r (ram_rdata)
  );

  gcidw_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  gcidw_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (norm_r),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

endmodule

// File: sv/grid_corner_idw_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_corner_idw_interpolator_top - inverse-distance grid interpolator
// Grid of up to four axes in a 4096-word store, queried at fractional points.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words (in_valid/in_ready): in_operation 0 stores in_write_value at
//    in_write_address (first axis fastest) and yields no result, and the block
//    stays ready. in_operation 1 is a query with Q7.8 coordinates
//    in_coord_a..d; it yields one result word.
//  - Query steps, n = 2^rank corners: corner distances, then the
//    weight-product loop on the one shared 25x18 multiplier, then the
//    weighted sum; the divider adds 44 one-bit steps. in_ready stays low
//    for the whole query.
//  - With element_count zero a query returns status 1, value 0.
//  - Result words (out_valid/out_ready) sit in an output register. A stalled
//    receiver holds the result; the next input word is still taken, and a
//    later query waits in its last step until the register frees up.
//  - Configuration: APB-style, register i at byte address 4*i, pready tied
//    high; the user writes only while no query is in flight (not enforced).
//  - Reset (rst_n low, synchronous) clears the sequencer, the output valid and
//    the registers to axis_count 1, sizes 1, element_count 0. The grid store
//    is not cleared; read only entries that have been written.
// ----------------------------------------------------------------------------
module grid_corner_idw_interpolator_top import gcidw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [PADDR_W-1:0]  cfg_paddr,
  input  logic [PDATA_W-1:0]  cfg_pwdata,
  output logic [PDATA_W-1:0]  cfg_prdata,
  output logic                cfg_pready,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [ADDR_W-1:0]   in_write_address,
  input  logic signed [VALUE_W-1:0] in_write_value,
  input  logic signed [COORD_W-1:0] in_coord_a,
  input  logic signed [COORD_W-1:0] in_coord_b,
  input  logic signed [COORD_W-1:0] in_coord_c,
  input  logic signed [COORD_W-1:0] in_coord_d,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [VALUE_W-1:0] out_interpolated,
  output logic                out_status
);

  logic [RANK_W-1:0]  axis_count_r;
  logic [SIZE_W-1:0]  axis_size_r [MAX_AXES];
  logic [COUNT_W-1:0] element_count_r;
  cfg_t               cfg;
  reg_idx_t           reg_idx;
  logic               cfg_wr;
  logic [MAX_AXES-1:0][COORD_W-1:0] coords;
  logic [VALUE_W-1:0] interp;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[PADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r    <= RANK_W'(1);
      for (int j = 0; j < MAX_AXES; j++) axis_size_r[j] <= SIZE_W'(1);
      element_count_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_AXIS_COUNT:    axis_count_r    <= cfg_pwdata[RANK_W-1:0];
        REG_AXIS0_SIZE:    axis_size_r[0]  <= cfg_pwdata[SIZE_W-1:0];
        REG_AXIS1_SIZE:    axis_size_r[1]  <= cfg_pwdata[SIZE_W-1:0];
        REG_AXIS2_SIZE:    axis_size_r[2]  <= cfg_pwdata[SIZE_W-1:0];
        REG_AXIS3_SIZE:    axis_size_r[3]  <= cfg_pwdata[SIZE_W-1:0];
        REG_ELEMENT_COUNT: element_count_r <= cfg_pwdata[COUNT_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_AXIS_COUNT:    cfg_prdata = PDATA_W'(axis_count_r);
      REG_AXIS0_SIZE:    cfg_prdata = PDATA_W'(axis_size_r[0]);
      REG_AXIS1_SIZE:    cfg_prdata = PDATA_W'(axis_size_r[1]);
      REG_AXIS2_SIZE:    cfg_prdata = PDATA_W'(axis_size_r[2]);
      REG_AXIS3_SIZE:    cfg_prdata = PDATA_W'(axis_size_r[3]);
      REG_ELEMENT_COUNT: cfg_prdata = PDATA_W'(element_count_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.axis_count    = axis_count_r;
    for (int j = 0; j < MAX_AXES; j++) cfg.axis_size[j] = axis_size_r[j];
    cfg.element_count = element_count_r;
  end

  assign coords = {in_coord_d, in_coord_c, in_coord_b, in_coord_a};
  assign out_interpolated = interp;

  gcidw_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_write_address   (in_write_address),
    .in_write_value     (in_write_value),
    .in_coord           (coords),
    .out_ready          (out_ready),
    .out_valid_r        (out_valid),
    .out_interpolated_r (interp),
    .out_status_r       (out_status)
  );

endmodule

// File: sv/gcidw_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcidw_chk - port-level checks
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module gcidw_chk import gcidw_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_operation,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] out_interpolated,
  input logic               out_status,
  input logic               cfg_pready
);

  // stalled result word is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a failed query carries a zero value
  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_interpolated == '0)
    else $error("no-data result with nonzero value");

  // a query keeps the block busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation |=> !in_ready)
    else $error("ready right after a query");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind grid_corner_idw_interpolator_top gcidw_chk u_chk (.*);

// File: bench/grid_corner_idw_interpolator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_corner_idw_interpolator_top_test - self-checking bench for the grid
// corner interpolator
// Loads grid values, programs the axis registers over APB and fires queries.
// Every query result is predicted in fixed point from a local copy of the
// grid and registers, then compared field by field in arrival order.
// ----------------------------------------------------------------------------
module grid_corner_idw_interpolator_top_test;
  import gcidw_pkg::*;

  typedef enum logic {OP_WRITE = 1'b0, OP_QUERY = 1'b1} op_t;
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_NO_DATA = 1'b1;
  localparam int   SETTLE_CYCLES = 600;   // longer than a four-axis query

  typedef struct packed {
    op_t                        op;
    logic [ADDR_W-1:0]          addr;
    logic [VALUE_W-1:0]         val;
    logic [3:0][COORD_W-1:0]    crd;
  } word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  // DUT inputs, all driven to known values from time zero
  logic                cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr = '0;
  logic [PDATA_W-1:0]  cfg_pwdata = '0;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_operation = 1'b0;
  logic [ADDR_W-1:0]   in_write_address = '0;
  logic signed [VALUE_W-1:0] in_write_value = '0;
  logic signed [COORD_W-1:0] in_coord_a = '0, in_coord_b = '0;
  logic signed [COORD_W-1:0] in_coord_c = '0, in_coord_d = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_interpolated;
  logic                out_status;

  grid_corner_idw_interpolator_top u_top (.*);

  // shadow of the block's registers and grid store
  logic [RANK_W-1:0]   sh_rank = 3'd1;
  logic [SIZE_W-1:0]   sh_size [4] = '{7'd1, 7'd1, 7'd1, 7'd1};
  logic [COUNT_W-1:0]  sh_count = '0;
  logic [VALUE_W-1:0]  grid_copy [GRID_DEPTH];
  bit                  grid_loaded [GRID_DEPTH];

  result_t pending_results[$];
  int err_count, n_writes, n_queries, n_results;

  // stimulus pacing knobs, shared with the receiver
  bit no_gaps;          // sender sends back to back while set
  int hold_len;         // long receiver hold-off, consumed by the receiver
  bit rx_calm;          // receiver takes every word at once while set
  int rx_wait;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic int used_rank();
    if (sh_rank < 1) return 1;
    if (sh_rank > MAX_AXES) return MAX_AXES;
    return sh_rank;
  endfunction

  function automatic int used_size(input int j);
    return (sh_size[j] < 1) ? 1 : int'(sh_size[j]);
  endfunction

  // lower cell index on one axis; singleton axes always sit on index 0
  function automatic longint lower_index(input int j, input logic [COORD_W-1:0] c);
    longint l;
    int sz;
    sz = used_size(j);
    if (sz == 1) return 0;
    l = ($signed(c) < 0) ? 0 : longint'($signed(c)) / 256;
    if (l >= sz - 1) l = sz - 2;
    return l;
  endfunction

  function automatic int corner_addr(input logic [3:0][COORD_W-1:0] crd, input int i);
    longint sub, stride, idx;
    sub = 0;
    stride = 1;
    for (int j = 0; j < used_rank(); j++) begin
      idx = (used_size(j) == 1) ? 0 : lower_index(j, crd[j]) + ((i >> j) & 1);
      sub += stride * idx;
      stride *= used_size(j);
    end
    return int'(sub % GRID_DEPTH);
  endfunction

  function automatic int bit_count(input longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic result_t interp_predict(input logic [3:0][COORD_W-1:0] crd);
    result_t r;
    int rank, n, sh;
    longint unsigned sq_dist [16], wgt [16], dmax, wmax, norm, m;
    longint f, d, acc, v;
    rank = used_rank();
    n = 1 << rank;
    if (sh_count == 0) begin
      r.value = '0;
      r.status = STAT_NO_DATA;
      return r;
    end
    // squared distance of the query point to every corner, Q16
    dmax = 0;
    for (int i = 0; i < n; i++) begin
      d = 0;
      for (int j = 0; j < rank; j++) begin
        if (used_size(j) == 1) begin
          d += 655;
        end else begin
          f = longint'($signed(crd[j])) - 256 * (lower_index(j, crd[j]) + ((i >> j) & 1));
          d += f * f;
        end
      end
      sq_dist[i] = d;
      if (sq_dist[i] > dmax) dmax = sq_dist[i];
    end
    // one common shift squeezes the distances into 16 bits; never lose a nonzero
    sh = (bit_count(dmax) > 16) ? bit_count(dmax) - 16 : 0;
    for (int i = 0; i < n; i++) begin
      m = sq_dist[i] >> sh;
      if (m == 0 && sq_dist[i] != 0) m = 1;
      sq_dist[i] = m;
      wgt[i] = 1;
    end
    // each weight collects the distances of all other corners, renormalized to 24 bits
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++)
        if (i != k) wgt[i] *= sq_dist[k];
      wmax = 0;
      for (int i = 0; i < n; i++)
        if (wgt[i] > wmax) wmax = wgt[i];
      sh = (bit_count(wmax) > 24) ? bit_count(wmax) - 24 : 0;
      for (int i = 0; i < n; i++) wgt[i] >>= sh;
    end
    acc = 0;
    norm = 0;
    for (int i = 0; i < n; i++) begin
      v = longint'($signed(grid_copy[corner_addr(crd, i)]));
      acc += longint'(wgt[i]) * v;
      norm += wgt[i];
    end
    r.value = (norm != 0) ? VALUE_W'(acc / longint'(norm)) : '0;
    r.status = STAT_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  // Leaves in_valid high on return; a drain or a gap in the next call lowers it.
  task automatic send_word(input word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation     = w.op;
    in_write_address = w.addr;
    in_write_value   = w.val;
    in_coord_a       = w.crd[0];
    in_coord_b       = w.crd[1];
    in_coord_c       = w.crd[2];
    in_coord_d       = w.crd[3];
    in_valid         = 1'b1;
    do @(posedge clk); while (!in_ready);
    // accepted: advance the shadow state in acceptance order
    if (w.op == OP_WRITE) begin
      grid_copy[w.addr] = w.val;
      grid_loaded[w.addr] = 1'b1;
      n_writes++;
    end else begin
      pending_results.push_back(interp_predict(w.crd));
      n_queries++;
    end
    @(negedge clk);
  endtask

  // ignored fields always carry random bits
  function automatic word_t rand_word(input op_t op);
    word_t w;
    w.op   = op;
    w.addr = ADDR_W'($urandom);
    w.val  = VALUE_W'($urandom);
    for (int j = 0; j < 4; j++) w.crd[j] = COORD_W'($urandom);
    return w;
  endfunction

  task automatic write_grid(input int addr, input logic [VALUE_W-1:0] val);
    word_t w;
    w = rand_word(OP_WRITE);
    w.addr = ADDR_W'(addr);
    w.val = val;
    send_word(w);
  endtask

  // if element_count is nonzero, loads unwritten corners the query reads, then queries
  task automatic query_at(input logic [3:0][COORD_W-1:0] crd);
    word_t w;
    int a;
    if (sh_count != 0) begin
      for (int i = 0; i < (1 << used_rank()); i++) begin
        a = corner_addr(crd, i);
        if (!grid_loaded[a]) write_grid(a, VALUE_W'($urandom));
      end
    end
    w = rand_word(OP_QUERY);
    w.crd = crd;
    send_word(w);
  endtask

  // mostly near the grid, some exact grid points, some anywhere
  function automatic logic [3:0][COORD_W-1:0] rand_coords();
    logic [3:0][COORD_W-1:0] crd;
    int sz;
    for (int j = 0; j < 4; j++) begin
      sz = used_size(j);
      case ($urandom_range(0, 9))
        0, 1: crd[j] = COORD_W'($urandom);
        2, 3: crd[j] = COORD_W'(256 * $urandom_range(0, sz - 1));
        default: crd[j] = COORD_W'(int'($urandom_range(0, (sz + 1) * 256)) - 128);
      endcase
    end
    return crd;
  endfunction

  // sender pauses until every expected result has come back
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- config
  task automatic cfg_write(input reg_idx_t r, input int value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = PADDR_W'(4 * int'(r));
    cfg_pwdata  = PDATA_W'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (r)
      REG_AXIS_COUNT:    sh_rank = RANK_W'(value);
      REG_AXIS0_SIZE:    sh_size[0] = SIZE_W'(value);
      REG_AXIS1_SIZE:    sh_size[1] = SIZE_W'(value);
      REG_AXIS2_SIZE:    sh_size[2] = SIZE_W'(value);
      REG_AXIS3_SIZE:    sh_size[3] = SIZE_W'(value);
      REG_ELEMENT_COUNT: sh_count = COUNT_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // writes go out only once the block has gone quiet
  task automatic set_grid(input int rank, input int s0, input int s1, input int s2,
                          input int s3, input int count);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write(REG_AXIS_COUNT, rank);
    cfg_write(REG_AXIS0_SIZE, s0);
    cfg_write(REG_AXIS1_SIZE, s1);
    cfg_write(REG_AXIS2_SIZE, s2);
    cfg_write(REG_AXIS3_SIZE, s3);
    cfg_write(REG_ELEMENT_COUNT, count);
  endtask

  // ---------------------------------------------------------------- receiver
  // Draws a stall per result; a requested hold-off is counted down here.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ready = 1'b0;
        hold_len--;
      end else if (rx_wait > 0) begin
        out_ready = 1'b0;
        rx_wait--;
      end else begin
        out_ready = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                    out_interpolated, out_status));
        end else begin
          result_t exp_r;
          exp_r = pending_results.pop_front();
          if (out_status !== exp_r.status)
            report_mismatch($sformatf("status got %0b want %0b", out_status, exp_r.status));
          if (out_interpolated !== $signed(exp_r.value))
            report_mismatch($sformatf("interpolated got %0d want %0d",
                                      out_interpolated, $signed(exp_r.value)));
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // Queries while element_count is zero report no data, even after a grid write.
  task automatic test_no_data();
    write_grid(0, 16'h1234);
    repeat (3) query_at(rand_coords());
  endtask

  // Extremes of values and coordinates, grid points, singleton axes,
  // out-of-range axis count and sizes.
  task automatic test_directed();
    logic [3:0][COORD_W-1:0] crd;
    set_grid(1, 2, 1, 1, 1, 1);
    write_grid(0, 16'h7FFF);
    write_grid(1, 16'h8000);
    write_grid(GRID_DEPTH - 1, 16'hFFFF);
    crd = '0;
    query_at(crd);                     // exactly on a grid point
    crd[0] = 16'sd128;
    query_at(crd);                     // midway
    crd[0] = 16'h8000;
    query_at(crd);                     // negative clamps to index 0
    crd[0] = 16'h7FFF;
    query_at(crd);                     // far past the top end
    set_grid(0, 0, 0, 0, 0, 8191);     // rank 0 acts as 1, size 0 as singleton
    query_at(rand_coords());
    set_grid(7, 64, 64, 64, 64, 4096); // rank 7 acts as 4, store wraps
    crd = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h3F00};
    query_at(crd);
    set_grid(4, 127, 1, 2, 127, 1);
    query_at(rand_coords());
  endtask

  // Receiver stalls for a long time while the sender keeps pushing queries.
  task automatic test_backpressure();
    set_grid(2, 4, 4, 1, 1, 16);
    no_gaps = 1'b1;
    hold_len = 1500;
    repeat (8) query_at(rand_coords());
    no_gaps = 1'b0;
    drain();
  endtask

  // Random phases: random config, then a mix of writes and queries,
  // about 70 input words per phase including corner preloads.
  task automatic test_random();
    int rank, lim, count, base, s [4];
    base = n_writes + n_queries;
    for (int p = 0; p < 10; p++) begin
      rank = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      lim = (rank <= 2) ? 64 : 8;
      for (int j = 0; j < 4; j++) begin
        case ($urandom_range(0, 11))
          0: s[j] = 0;
          1: s[j] = 127;
          2: s[j] = 64;
          default: s[j] = $urandom_range(1, lim);
        endcase
      end
      count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8191);
      set_grid(rank, s[0], s[1], s[2], s[3], count);
      while (n_writes + n_queries < base + 70 * (p + 1)) begin
        if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
        if ($urandom_range(0, 9) < 3) write_grid($urandom_range(0, GRID_DEPTH - 1),
                                                 VALUE_W'($urandom));
        else query_at(rand_coords());
      end
      no_gaps = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_no_data();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d grid writes and %0d queries, %0d results checked,",
             n_writes, n_queries, n_results);
    $display("over ranks 1..4, clamped and singleton axes, no-data and long stalls");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("grid_corner_idw_interpolator_top_test: done, clean");
    end else begin
      $display("grid_corner_idw_interpolator_top_test: done, errors");
    end
    $finish;
  end

  // generous watchdog
  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("grid_corner_idw_interpolator_top_test: done, errors");
    $finish;
  end

endmodule
